// ===== hw/rtl/mmts_pkg.sv =====
package mmts_pkg;

  // Default table depth and fixed field widths.
  localparam int DEPTH_DEF   = 1024;
  localparam int CNT_W       = 11;
  localparam int IDX_W       = 10;
  localparam int POS_W       = 10;
  localparam int VAL_W       = 32;
  localparam int MODE_W      = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 16;

  // Configuration register reset values.
  localparam logic [CNT_W-1:0] CNT_RST  = 11'd1024;
  localparam logic [CNT_W-1:0] STEP_RST = 11'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_STEP   = 4'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 3'd0,
    MODE_LINEAR  = 3'd1,
    MODE_ORDERED = 3'd2,
    MODE_JUMP    = 3'd3,
    MODE_BINARY  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIN_SCAN,
    ST_ORD_LAST,
    ST_ORD_SCAN,
    ST_JMP_LAST,
    ST_BIN_PROBE,
    ST_DONE
  } state_e;

  // Address register updates performed by the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LIN_START,
    OP_ORD_START,
    OP_JMP_START,
    OP_BIN_START,
    OP_SCAN_NEXT,
    OP_SCAN_BLOCK,
    OP_JMP_NEXT,
    OP_BIN_LOWER,
    OP_BIN_UPPER
  } dp_op_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_HIT,
    RES_MISS
  } res_op_e;

  typedef struct packed {
    logic    capture;
    logic    mem_write;
    dp_op_e  op;
    res_op_e res;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic key_eq;
    logic key_lt;
    logic key_gt;
    logic scan_end;
    logic jmp_over;
    logic bin_lo_end;
    logic bin_hi_end;
    logic n_zero;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== hw/rtl/mmts_ctrl.sv =====
module mmts_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [mmts_pkg::MODE_W-1:0] in_mode_i,
  output logic                      in_ready_o,
  input  mmts_pkg::dp_stat_t        stat_i,
  output mmts_pkg::dp_cmd_t         cmd_o
);
  import mmts_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.mem_write = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.res      = RES_NONE;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.res     = RES_MISS;
          state_d       = ST_DONE;
          unique case (mode_e'(in_mode_i))
            MODE_WRITE: begin
              cmd_o.mem_write = 1'b1;
            end
            MODE_LINEAR: begin
              if (!stat_i.n_zero) begin
                cmd_o.op  = OP_LIN_START;
                cmd_o.res = RES_NONE;
                state_d   = ST_LIN_SCAN;
              end
            end
            MODE_ORDERED: begin
              if (!stat_i.n_zero) begin
                cmd_o.op  = OP_ORD_START;
                cmd_o.res = RES_NONE;
                state_d   = ST_ORD_LAST;
              end
            end
            MODE_JUMP: begin
              if (!stat_i.n_zero) begin
                cmd_o.op  = OP_JMP_START;
                cmd_o.res = RES_NONE;
                state_d   = ST_JMP_LAST;
              end
            end
            MODE_BINARY: begin
              if (!stat_i.n_zero) begin
                cmd_o.op  = OP_BIN_START;
                cmd_o.res = RES_NONE;
                state_d   = ST_BIN_PROBE;
              end
            end
            default: begin
              // Unused modes only report a miss.
            end
          endcase
        end
      end
      ST_LIN_SCAN: begin
        if (stat_i.key_eq) begin
          cmd_o.res = RES_HIT;
          state_d   = ST_DONE;
        end else if (stat_i.scan_end) begin
          cmd_o.res = RES_MISS;
          state_d   = ST_DONE;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
        end
      end
      ST_ORD_LAST: begin
        // A key above the last entry misses without a scan.
        if (stat_i.key_gt) begin
          cmd_o.res = RES_MISS;
          state_d   = ST_DONE;
        end else begin
          cmd_o.op = OP_LIN_START;
          state_d  = ST_ORD_SCAN;
        end
      end
      ST_ORD_SCAN: begin
        if (stat_i.key_eq) begin
          cmd_o.res = RES_HIT;
          state_d   = ST_DONE;
        end else if (stat_i.key_lt || stat_i.scan_end) begin
          cmd_o.res = RES_MISS;
          state_d   = ST_DONE;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
        end
      end
      ST_JMP_LAST: begin
        if (!stat_i.key_gt) begin
          cmd_o.op = OP_SCAN_BLOCK;
          state_d  = ST_LIN_SCAN;
        end else if (stat_i.jmp_over) begin
          cmd_o.res = RES_MISS;
          state_d   = ST_DONE;
        end else begin
          cmd_o.op = OP_JMP_NEXT;
        end
      end
      ST_BIN_PROBE: begin
        if (stat_i.key_eq) begin
          cmd_o.res = RES_HIT;
          state_d   = ST_DONE;
        end else if (stat_i.key_lt) begin
          if (stat_i.bin_lo_end) begin
            cmd_o.res = RES_MISS;
            state_d   = ST_DONE;
          end else begin
            cmd_o.op = OP_BIN_LOWER;
          end
        end else begin
          if (stat_i.bin_hi_end) begin
            cmd_o.res = RES_MISS;
            state_d   = ST_DONE;
          end else begin
            cmd_o.op = OP_BIN_UPPER;
          end
        end
      end
      ST_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mmts_dp.sv =====
module mmts_dp #(
  parameter int DEPTH = mmts_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mmts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mmts_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic [mmts_pkg::IDX_W-1:0]    in_index_i,
  input  logic [mmts_pkg::VAL_W-1:0]    in_value_i,
  input  mmts_pkg::dp_cmd_t             cmd_i,
  output mmts_pkg::dp_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_found_o,
  output logic [mmts_pkg::POS_W-1:0]    out_pos_o
);
  import mmts_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > CNT_W) ? CW : CNT_W) + 2;

  logic [CNT_W-1:0]        cnt_q, step_q;
  logic [VAL_W-1:0]        mem_q [DEPTH];
  logic signed [VAL_W-1:0] rdata_q, key_q;
  logic [AW-1:0]           cur_q, cur_d, lim_q, lim_d, base_q, base_d;
  logic [AW-1:0]           lo_q, lo_d, hi_q, hi_d;
  logic                    res_found_q;
  logic [POS_W-1:0]        res_pos_q;
  logic                    out_valid_q, out_found_q;
  logic [POS_W-1:0]        out_pos_q;

  logic [XW-1:0] cnt_x, n_x, nm1_x, s_x, sm1_x, base_next_x, jmp_last_x;
  logic [AW:0]   mid_sum;
  logic [AW-1:0] cur_dec, cur_inc;
  logic          idx_ok;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CNT_RST;
      step_q <= STEP_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ENTRY_COUNT) begin
        cnt_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_JUMP_STEP) begin
        step_q <= cfg_data_i;
      end
    end
  end

  // Effective search span and jump step.
  assign cnt_x  = XW'(cnt_q);
  assign n_x    = (cnt_x > XW'(DEPTH)) ? XW'(DEPTH) : cnt_x;
  assign nm1_x  = n_x - XW'(1);
  assign s_x    = (step_q == '0) ? XW'(1) : XW'(step_q);
  assign sm1_x  = s_x - XW'(1);

  // Next jump block and its last element, clipped to the span.
  assign base_next_x = XW'(base_q) + s_x;
  assign jmp_last_x  = base_next_x + sm1_x;
  assign cur_dec     = cur_q - AW'(1);
  assign cur_inc     = cur_q + AW'(1);

  // Address register updates.
  always_comb begin
    cur_d   = cur_q;
    lim_d   = lim_q;
    base_d  = base_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_sum = '0;
    case (cmd_i.op)
      OP_LIN_START: begin
        cur_d = '0;
        lim_d = AW'(nm1_x);
      end
      OP_ORD_START: begin
        cur_d = AW'(nm1_x);
      end
      OP_JMP_START: begin
        base_d = '0;
        cur_d  = (sm1_x > nm1_x) ? AW'(nm1_x) : AW'(sm1_x);
      end
      OP_BIN_START: begin
        lo_d  = '0;
        hi_d  = AW'(nm1_x);
        cur_d = AW'(nm1_x >> 1);
      end
      OP_SCAN_NEXT: begin
        cur_d = cur_inc;
      end
      OP_SCAN_BLOCK: begin
        cur_d = base_q;
        lim_d = cur_q;
      end
      OP_JMP_NEXT: begin
        base_d = AW'(base_next_x);
        cur_d  = (jmp_last_x > nm1_x) ? AW'(nm1_x) : AW'(jmp_last_x);
      end
      OP_BIN_LOWER: begin
        hi_d    = cur_dec;
        mid_sum = {1'b0, lo_q} + {1'b0, cur_dec};
        cur_d   = mid_sum[AW:1];
      end
      OP_BIN_UPPER: begin
        lo_d    = cur_inc;
        mid_sum = {1'b0, cur_inc} + {1'b0, hi_q};
        cur_d   = mid_sum[AW:1];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    lim_q  <= lim_d;
    base_q <= base_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    if (cmd_i.capture) begin
      key_q <= in_value_i;
    end
  end

  // Table memory: one write port, one registered read port.
  assign idx_ok = (32'(in_index_i) < DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_write && idx_ok) begin
      mem_q[AW'(in_index_i)] <= in_value_i;
    end
    rdata_q <= mem_q[cur_d];
  end

  // Status toward the controller.
  assign stat_o.key_eq     = (key_q == rdata_q);
  assign stat_o.key_lt     = (key_q < rdata_q);
  assign stat_o.key_gt     = (key_q > rdata_q);
  assign stat_o.scan_end   = (cur_q == lim_q);
  assign stat_o.jmp_over   = (base_next_x >= n_x);
  assign stat_o.bin_lo_end = (cur_q == lo_q);
  assign stat_o.bin_hi_end = (cur_q == hi_q);
  assign stat_o.n_zero     = (n_x == '0);
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  // Result of the current item.
  always_ff @(posedge clk_i) begin
    case (cmd_i.res)
      RES_HIT: begin
        res_found_q <= 1'b1;
        res_pos_q   <= POS_W'(cur_q);
      end
      RES_MISS: begin
        res_found_q <= 1'b0;
        res_pos_q   <= '0;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_found_q <= res_found_q;
      out_pos_q   <= res_pos_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_pos_o   = out_pos_q;

endmodule

// ===== hw/rtl/multi_mode_table_search_top.sv =====
// Flow: a write or a miss without probing goes from the idle state to the done state; a
// search first runs its probe states (linear up to n probes, ordered up to n + 1, jump up
// to ceil(n / jump_step) + jump_step, binary up to floor(log2(n)) + 1). The done state
// loads the output register behind m_axis_tvalid, waiting while it is held. One item
// at a time: the next is taken after the done state. One probe per cycle on one read port.
// Reset: entry_count returns to 1024 and jump_step to 2; the table is not cleared.
module multi_mode_table_search_top #(
  parameter int DEPTH = mmts_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mmts_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // index[9:0], value[41:10]
  input  logic [mmts_pkg::MODE_W-1:0]       s_axis_tuser,   // mode[2:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mmts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // position[9:0]
  output logic                              m_axis_tuser,   // found[0]
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mmts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mmts_pkg::CNT_W-1:0]        cfg_data_i
);
  import mmts_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [POS_W-1:0] out_pos;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  mmts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mmts_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_index_i  (s_axis_tdata[IDX_W-1:0]),
    .in_value_i  (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_found_o (m_axis_tuser),
    .out_pos_o   (out_pos)
  );

  assign m_axis_tdata = OUT_DATA_W'(out_pos);

endmodule

// ===== test/multi_mode_table_search_top_tb.sv =====
`timescale 1ns / 100ps

module multi_mode_table_search_top_tb;
  import mmts_pkg::*;

  localparam int TBL_DEPTH    = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 540;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 20000;
  localparam int N_ROWS       = 27;

  // Modes outside the defined set, and a register index that maps to nothing.
  localparam logic [MODE_W-1:0]    MODE_RSVD_FIRST = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_RSVD_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 4'hF;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

  // One directed row: either a register write or an item, with an optional typed result.
  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CNT_W-1:0]     cfg_data;
    logic [MODE_W-1:0]    mode;
    logic [IDX_W-1:0]     idx;
    logic [VAL_W-1:0]     val;
    logic                 has_typed;
    result_t              typed;
  } row_t;

  localparam result_t MISS = '{1'b0, 10'd0};

  localparam row_t DIRECTED_ROWS [N_ROWS] = '{
    '{1'b0, 4'd0, 11'd0, MODE_WRITE, 10'd0, 32'h8000_0000, 1'b1, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_RSVD_LAST, 10'd1023, 32'hFFFF_FFFF, 1'b1, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_RSVD_FIRST, 10'd0, 32'h0000_0000, 1'b1, MISS},
    '{1'b1, CFG_ENTRY_COUNT, 11'd4, MODE_WRITE, 10'd0, 32'h0, 1'b0, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_WRITE, 10'd1, 32'hFFFF_FFFB, 1'b1, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_WRITE, 10'd2, 32'h0000_0000, 1'b1, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_WRITE, 10'd3, 32'h7FFF_FFFF, 1'b1, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_LINEAR, 10'd0, 32'h8000_0000, 1'b1, '{1'b1, 10'd0}},
    '{1'b0, 4'd0, 11'd0, MODE_LINEAR, 10'd1023, 32'h7FFF_FFFF, 1'b1, '{1'b1, 10'd3}},
    '{1'b0, 4'd0, 11'd0, MODE_ORDERED, 10'd0, 32'h7FFF_FFFF, 1'b1, '{1'b1, 10'd3}},
    '{1'b0, 4'd0, 11'd0, MODE_ORDERED, 10'd0, 32'h0000_0005, 1'b0, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_JUMP, 10'd0, 32'h0000_0000, 1'b0, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_BINARY, 10'd0, 32'hFFFF_FFFB, 1'b0, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_BINARY, 10'd0, 32'h0000_0001, 1'b0, MISS},
    '{1'b1, CFG_JUMP_STEP, 11'd0, MODE_WRITE, 10'd0, 32'h0, 1'b0, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_JUMP, 10'd0, 32'h7FFF_FFFF, 1'b0, MISS},
    '{1'b1, CFG_ENTRY_COUNT, 11'd0, MODE_WRITE, 10'd0, 32'h0, 1'b0, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_LINEAR, 10'd0, 32'h0000_0000, 1'b1, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_ORDERED, 10'd0, 32'h8000_0000, 1'b1, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_JUMP, 10'd0, 32'h0000_0000, 1'b1, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_BINARY, 10'd0, 32'h0000_0000, 1'b1, MISS},
    '{1'b1, CFG_UNUSED, 11'd2047, MODE_WRITE, 10'd0, 32'h0, 1'b0, MISS},
    '{1'b1, CFG_JUMP_STEP, 11'd2047, MODE_WRITE, 10'd0, 32'h0, 1'b0, MISS},
    '{1'b1, CFG_ENTRY_COUNT, 11'd3, MODE_WRITE, 10'd0, 32'h0, 1'b0, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_JUMP, 10'd0, 32'h0000_0000, 1'b0, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_WRITE, 10'd1023, 32'h0000_007B, 1'b1, MISS},
    '{1'b0, 4'd0, 11'd0, MODE_LINEAR, 10'd0, 32'h0000_007B, 1'b0, MISS}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [MODE_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CNT_W-1:0]      cfg_data_i;

  // Mirror of the table contents and of both registers.
  int               table_mirror [TBL_DEPTH];
  logic [CNT_W-1:0] count_mirror = CNT_RST;
  logic [CNT_W-1:0] step_mirror  = STEP_RST;

  result_t pending_results [$];
  int      mismatches   = 0;
  int      items_sent   = 0;
  int      stall_cycles = 0;
  bit      no_idle      = 1'b0;
  bit      hold_req     = 1'b0;

  multi_mode_table_search_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Returns the first index in [from, to] whose entry equals the key, or -1.
  function automatic int scan_for(int from, int to, int key);
    for (int i = from; i <= to; i++) begin
      if (table_mirror[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one item to the mirror and returns the result the block should give.
  function automatic result_t lookup_outcome(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                                             int key);
    result_t r;
    int      n;
    int      step;
    int      hit;
    int      last;
    int      lo;
    int      hi;
    int      mid;
    r   = '0;
    hit = -1;
    n   = (count_mirror > TBL_DEPTH) ? TBL_DEPTH : int'(count_mirror);
    case (mode)
      MODE_WRITE: begin
        if (idx < TBL_DEPTH) table_mirror[idx] = key;
      end
      MODE_LINEAR: begin
        if (n != 0) hit = scan_for(0, n - 1, key);
      end
      MODE_ORDERED: begin
        // A key above the last entry misses at once; otherwise stop at the first larger entry.
        if (n != 0 && key <= table_mirror[n - 1]) begin
          for (int i = 0; i < n; i++) begin
            if (table_mirror[i] > key) break;
            if (table_mirror[i] == key) begin
              hit = i;
              break;
            end
          end
        end
      end
      MODE_JUMP: begin
        step = (step_mirror == 0) ? 1 : int'(step_mirror);
        for (int i = 0; i < n; i += step) begin
          last = i + step - 1;
          if (last > n - 1) last = n - 1;
          if (table_mirror[last] >= key) begin
            hit = scan_for(i, last, key);
            break;
          end
        end
      end
      MODE_BINARY: begin
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (table_mirror[mid] == key) begin
            hit = mid;
            break;
          end
          if (key < table_mirror[mid]) hi = mid - 1;
          else lo = mid + 1;
        end
      end
      default: ;
    endcase
    if (hit >= 0) begin
      r.found    = 1'b1;
      r.position = hit[POS_W-1:0];
    end
    return r;
  endfunction

  // Offers one item, waits for its acceptance and records the expected result.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input bit has_typed = 1'b0,
                           input result_t typed = '0);
    result_t predicted;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 38) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = mode;
    s_axis_tdata  = {{(IN_DATA_W - IDX_W - VAL_W){1'b0}}, val, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = lookup_outcome(mode, idx, val);
    pending_results.push_back(has_typed ? typed : predicted);
    items_sent++;
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_ENTRY_COUNT) count_mirror = data;
    else if (idx == CFG_JUMP_STEP) step_mirror = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Fills entries 0 .. n-1, mostly in ascending order with duplicates and saturation.
  task automatic fill_table(input int n, input bit sorted);
    longint cur;
    int     spread;
    case ($urandom_range(2))
      0: cur = -64'sd2147483648;
      1: cur = -100;
      default: cur = int'($urandom);
    endcase
    case ($urandom_range(2))
      0: spread = 3;
      1: spread = 1000;
      default: spread = 1 << 24;
    endcase
    for (int i = 0; i < n; i++) begin
      cur += $urandom_range(spread);
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      send_item(MODE_WRITE, i[IDX_W-1:0], sorted ? cur[VAL_W-1:0] : $urandom);
    end
  endtask

  // Picks a key: mostly a stored value, else a neighbor, a random word or an extreme.
  function automatic int pick_key(int n);
    int sel;
    int ref_val;
    sel = $urandom_range(99);
    if (n == 0) return int'($urandom);
    ref_val = table_mirror[$urandom_range(n - 1)];
    if (sel < 55) return ref_val;
    if (sel < 75) return $urandom_range(1) ? ref_val + 1 : ref_val - 1;
    if (sel < 90) return int'($urandom);
    return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  // Mostly searches, with some reserved modes and stray writes mixed in.
  task automatic run_searches(input int count, input int n);
    int               sel;
    logic [IDX_W-1:0] widx;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 88) begin
        send_item(MODE_W'($urandom_range(MODE_BINARY, MODE_LINEAR)), IDX_W'($urandom),
                  pick_key(n));
      end else if (sel < 94) begin
        send_item(MODE_W'($urandom_range(MODE_RSVD_LAST, MODE_RSVD_FIRST)), IDX_W'($urandom),
                  $urandom);
      end else begin
        widx = (n > 0 && $urandom_range(1)) ? IDX_W'($urandom_range(n - 1))
                                            : IDX_W'($urandom);
        send_item(MODE_WRITE, widx, $urandom);
      end
    end
  endtask

  // Result checker: every accepted result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result found=%0d position=%0d", $time, m_axis_tuser,
                 m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.found ||
            m_axis_tdata !== {{(OUT_DATA_W - POS_W){1'b0}}, want.position}) begin
          $display("%0t: mismatch expected found=%0d position=%0d, actual found=%0d tdata=%0d",
                   $time, want.found, want.position, m_axis_tuser, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random back-pressure, with one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready = no_idle || ($urandom_range(99) >= 38);
      end
    end
  end

  // Watchdog on cycles in which no handshake of any kind completes.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[multi_mode_table_search_top] ERROR");
      $finish;
    end
  end

  // Main stimulus sequence.
  initial begin
    int n;
    int step;
    int phase;
    int n_items;
    row_t row;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extremes, every mode and the corner cases.
    n_items = 0;
    for (int r = 0; r < N_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.is_cfg) begin
        write_reg(row.cfg_idx, row.cfg_data);
      end else begin
        send_item(row.mode, row.idx, row.val, row.has_typed, row.typed);
        n_items++;
      end
    end

    // Random phases: configure, fill the searched span, then search it.
    phase = 0;
    while (items_sent < n_items + RANDOM_ITEMS) begin
      case ($urandom_range(99)) inside
        [0:4]:   n = 0;
        [5:79]:  n = $urandom_range(16, 1);
        [80:96]: n = $urandom_range(64, 17);
        default: n = $urandom_range(200, 65);
      endcase
      write_reg(CFG_ENTRY_COUNT, CNT_W'(n));
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(9))
          0: step = 0;
          1: step = 1;
          2: step = 2047;
          3: step = n;
          default: step = $urandom_range(n + 3, 1);
        endcase
        write_reg(CFG_JUMP_STEP, CNT_W'(step));
      end
      // A few early phases run with no idling on either side.
      no_idle = (phase >= 1 && phase <= 4);
      // Long receiver hold-off while the sender keeps offering writes.
      if (phase == 2) hold_req = 1'b1;
      fill_table(n, $urandom_range(99) < 85);
      run_searches($urandom_range(20, 8), n);
      phase++;
    end
    no_idle = 1'b0;

    // Counts at and above the depth: with the last entry below the key, ordered and
    // jump searches read only that entry and miss.
    write_reg(CFG_ENTRY_COUNT, CNT_W'(TBL_DEPTH));
    write_reg(CFG_JUMP_STEP, 11'd2047);
    send_item(MODE_WRITE, 10'd1023, 32'h0000_007B);
    send_item(MODE_ORDERED, 10'd0, 32'h7FFF_FFFF);
    send_item(MODE_JUMP, 10'd0, 32'h7FFF_FFFF);
    write_reg(CFG_ENTRY_COUNT, 11'd2047);
    write_reg(CFG_JUMP_STEP, 11'd1024);
    send_item(MODE_ORDERED, 10'd0, 32'h0000_007C);
    send_item(MODE_JUMP, 10'd0, 32'h7FFF_FFFF);
    send_item(MODE_ORDERED, 10'd0, 32'h7FFF_FFFF);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[multi_mode_table_search_top] OK");
    end else begin
      $display("[multi_mode_table_search_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== multi_mode_table_search_top.f =====
hw/rtl/mmts_pkg.sv
hw/rtl/mmts_ctrl.sv
hw/rtl/mmts_dp.sv
hw/rtl/multi_mode_table_search_top.sv
test/multi_mode_table_search_top_tb.sv
